>>> design/dga_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dga_pkg
// Shared widths, codes and types for the distance gain attenuation pipeline.
// ----------------------------------------------------------------------------
package dga_pkg;

  localparam int DIST_W    = 24;              // distance and register width
  localparam int SQ_W      = 2 * DIST_W;      // one squared axis difference
  localparam int SUM_W     = SQ_W + 2;        // sum of three squares
  localparam int ROOT_W    = DIST_W + 1;      // floor(sqrt(sum)) < 2^25
  localparam int QUOT_W    = 15;              // quotient bits of the ramp
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 16'h8000;

  localparam logic [CFG_IDX_W-1:0] CFG_NEAR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR  = 1'b1;

  localparam logic [DIST_W-1:0] NEAR_RST = 24'd256;
  localparam logic [DIST_W-1:0] FAR_RST  = 24'd12800;

  typedef enum logic [1:0] {
    MODE_CALC = 2'd0,
    MODE_FULL = 2'd1,
    MODE_ZERO = 2'd2
  } mode_e;

  // travels with each transaction down the pipe
  typedef struct packed {
    logic  gain_valid;
    mode_e mode;
  } tag_t;

endpackage

`default_nettype wire

>>> design/distance_gain_attenuation_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// distance_gain_attenuation_top
// Linear 3D distance attenuation: exact distance between source and
// listener, full gain up to near, linear fall to zero at far.
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-----------------------------------
//  in       | in_valid_i / in_stall_o     | source_*_i, listener_*_i, flags
//  out      | out_valid_o / out_stall_i   | gain_o, gain_valid_o
//  cfg      | cfg_we_i                    | cfg_idx_i, cfg_wdata_i
//
//  One transaction per cycle unless the output stalls. The pipe runs through
//  distance, square root, classify, divide and output register stages; the
//  root and divider resolve one bit per stage. A stalled output register
//  freezes the whole pipe, so in_stall_o follows out_stall_i while a result
//  is held. Reset clears all valid bits and loads near = 256, far = 12800.
// ----------------------------------------------------------------------------
module distance_gain_attenuation_top #(
  parameter int POS_WIDTH = 24
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,

  input  wire logic                        cfg_we_i,
  input  wire logic [dga_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [dga_pkg::DIST_W-1:0]  cfg_wdata_i,

  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [POS_WIDTH-1:0]        source_x_i,
  input  wire logic [POS_WIDTH-1:0]        source_y_i,
  input  wire logic [POS_WIDTH-1:0]        source_z_i,
  input  wire logic [POS_WIDTH-1:0]        listener_x_i,
  input  wire logic [POS_WIDTH-1:0]        listener_y_i,
  input  wire logic [POS_WIDTH-1:0]        listener_z_i,
  input  wire logic                        listener_present_i,
  input  wire logic                        force_full_i,

  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [dga_pkg::GAIN_W-1:0]       gain_o,
  output logic                             gain_valid_o
);

  logic [dga_pkg::DIST_W-1:0] near_q, far_q;
  logic en;

  logic                         sq_valid;
  logic [dga_pkg::SUM_W-1:0]    sq_sum;
  dga_pkg::tag_t                sq_tag;
  logic                         rt_valid;
  logic [dga_pkg::ROOT_W-1:0]   rt_root;
  dga_pkg::tag_t                rt_tag;
  logic                         dv_valid;
  logic [dga_pkg::QUOT_W-1:0]   dv_quot;
  dga_pkg::tag_t                dv_tag;

  logic                         out_valid_q;
  logic [dga_pkg::GAIN_W-1:0]   gain_d, gain_q;
  logic                         gv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= dga_pkg::NEAR_RST;
      far_q  <= dga_pkg::FAR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        dga_pkg::CFG_NEAR: near_q <= cfg_wdata_i;
        dga_pkg::CFG_FAR:  far_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipe advances unless a finished result is held
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  dga_sqdist #(
    .PosW (POS_WIDTH)
  ) u_sqdist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .src_x_i   (source_x_i),
    .src_y_i   (source_y_i),
    .src_z_i   (source_z_i),
    .lis_x_i   (listener_x_i),
    .lis_y_i   (listener_y_i),
    .lis_z_i   (listener_z_i),
    .present_i (listener_present_i),
    .force_i   (force_full_i),
    .valid_o   (sq_valid),
    .sum_o     (sq_sum),
    .tag_o     (sq_tag)
  );

  dga_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_valid),
    .sum_i   (sq_sum),
    .tag_i   (sq_tag),
    .valid_o (rt_valid),
    .root_o  (rt_root),
    .tag_o   (rt_tag)
  );

  dga_ratio u_ratio (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rt_valid),
    .root_i  (rt_root),
    .tag_i   (rt_tag),
    .near_i  (near_q),
    .far_i   (far_q),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .tag_o   (dv_tag)
  );

  always_comb begin
    case (dv_tag.mode)
      dga_pkg::MODE_FULL: gain_d = dga_pkg::GAIN_ONE;
      dga_pkg::MODE_CALC: gain_d = dga_pkg::GAIN_W'(dv_quot);
      default:            gain_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      gain_q <= gain_d;
      gv_q   <= dv_tag.gain_valid;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign gain_o       = gain_q;
  assign gain_valid_o = gv_q;

endmodule

`default_nettype wire

>>> design/dga_sqdist.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dga_sqdist
// Squared Euclidean distance: abs differences, squares, sum (three stages).
// ----------------------------------------------------------------------------
module dga_sqdist #(
  parameter int PosW = 24
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [PosW-1:0]            src_x_i,
  input  wire logic [PosW-1:0]            src_y_i,
  input  wire logic [PosW-1:0]            src_z_i,
  input  wire logic [PosW-1:0]            lis_x_i,
  input  wire logic [PosW-1:0]            lis_y_i,
  input  wire logic [PosW-1:0]            lis_z_i,
  input  wire logic                       present_i,
  input  wire logic                       force_i,
  output logic                            valid_o,
  output logic [dga_pkg::SUM_W-1:0]       sum_o,
  output dga_pkg::tag_t                   tag_o
);

  localparam int DiffW = PosW + 1;
  localparam int MagW  = (DiffW > dga_pkg::DIST_W + 1) ? DiffW : dga_pkg::DIST_W + 1;

  logic [PosW-1:0] src [3];
  logic [PosW-1:0] lis [3];
  logic [2:0]      huge;
  logic [dga_pkg::DIST_W-1:0] mag_d [3];

  logic [dga_pkg::DIST_W-1:0] mag_q [3];
  logic [dga_pkg::SQ_W-1:0]   sq_q  [3];
  logic [dga_pkg::SUM_W-1:0]  sum_q;
  dga_pkg::tag_t tag1_d, tag1_q, tag2_q, tag3_q;
  logic v1_q, v2_q, v3_q;

  assign src[0] = src_x_i;
  assign src[1] = src_y_i;
  assign src[2] = src_z_i;
  assign lis[0] = lis_x_i;
  assign lis[1] = lis_y_i;
  assign lis[2] = lis_z_i;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [DiffW-1:0] diff;
    logic [DiffW-1:0] mag;
    logic [MagW-1:0]  mag_ext;
    assign diff    = {src[a][PosW-1], src[a]} - {lis[a][PosW-1], lis[a]};
    assign mag     = diff[DiffW-1] ? DiffW'(~diff + 1'b1) : diff;
    assign mag_ext = MagW'(mag);
    assign huge[a] = |mag_ext[MagW-1:dga_pkg::DIST_W];
    assign mag_d[a] = mag_ext[dga_pkg::DIST_W-1:0];
  end

  always_comb begin
    tag1_d.gain_valid = force_i | present_i;
    if (force_i) begin
      tag1_d.mode = dga_pkg::MODE_FULL;
    end else if (!present_i || (|huge)) begin
      // no listener, or separation beyond any register value
      tag1_d.mode = dga_pkg::MODE_ZERO;
    end else begin
      tag1_d.mode = dga_pkg::MODE_CALC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int a = 0; a < 3; a++) begin
        mag_q[a] <= mag_d[a];
        sq_q[a]  <= dga_pkg::SQ_W'(mag_q[a]) * dga_pkg::SQ_W'(mag_q[a]);
      end
      sum_q  <= dga_pkg::SUM_W'(sq_q[0]) + dga_pkg::SUM_W'(sq_q[1])
              + dga_pkg::SUM_W'(sq_q[2]);
      tag1_q <= tag1_d;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  assign valid_o = v3_q;
  assign sum_o   = sum_q;
  assign tag_o   = tag3_q;

endmodule

`default_nettype wire

>>> design/dga_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dga_isqrt
// Exact integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module dga_isqrt (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [dga_pkg::SUM_W-1:0]   sum_i,
  input  wire dga_pkg::tag_t               tag_i,
  output logic                             valid_o,
  output logic [dga_pkg::ROOT_W-1:0]       root_o,
  output dga_pkg::tag_t                    tag_o
);

  localparam int Steps = dga_pkg::ROOT_W;
  localparam int RW    = dga_pkg::SUM_W + 1;

  logic [RW-1:0] n_in [Steps];
  logic [RW-1:0] r_in [Steps];
  dga_pkg::tag_t t_in [Steps];
  logic          v_in [Steps];

  logic [RW-1:0] n_q [Steps];
  logic [RW-1:0] r_q [Steps];
  dga_pkg::tag_t t_q [Steps];
  logic          v_q [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    localparam logic [RW-1:0] Bit = RW'(1) << (2 * (Steps - 1 - s));
    logic [RW-1:0] trial;
    logic          take;

    if (s == 0) begin : g_first
      assign n_in[s] = RW'(sum_i);
      assign r_in[s] = '0;
      assign t_in[s] = tag_i;
      assign v_in[s] = valid_i;
    end else begin : g_next
      assign n_in[s] = n_q[s-1];
      assign r_in[s] = r_q[s-1];
      assign t_in[s] = t_q[s-1];
      assign v_in[s] = v_q[s-1];
    end

    assign trial = r_in[s] + Bit;
    assign take  = n_in[s] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[s] <= take ? n_in[s] - trial : n_in[s];
        r_q[s] <= take ? (r_in[s] >> 1) + Bit : r_in[s] >> 1;
        t_q[s] <= t_in[s];
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign root_o  = r_q[Steps-1][dga_pkg::ROOT_W-1:0];
  assign tag_o   = t_q[Steps-1];

endmodule

`default_nettype wire

>>> design/dga_ratio.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dga_ratio
// Near/far classification, then a restoring divide for the linear ramp:
// quot = floor(2^15 * (far - d) / (far - near)), one quotient bit a stage.
// ----------------------------------------------------------------------------
module dga_ratio (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [dga_pkg::ROOT_W-1:0]  root_i,
  input  wire dga_pkg::tag_t               tag_i,
  input  wire logic [dga_pkg::DIST_W-1:0]  near_i,
  input  wire logic [dga_pkg::DIST_W-1:0]  far_i,
  output logic                             valid_o,
  output logic [dga_pkg::QUOT_W-1:0]       quot_o,
  output dga_pkg::tag_t                    tag_o
);

  localparam int Steps = dga_pkg::QUOT_W;
  localparam int DW    = dga_pkg::DIST_W;

  // classification stage
  dga_pkg::tag_t  tag_c_d, tag_c_q;
  logic [DW-1:0]  num_c_d, num_c_q;
  logic [DW-1:0]  den_c_d, den_c_q;
  logic           v_c_q;
  logic [DW:0]    near_ext, far_ext;

  assign near_ext = {1'b0, near_i};
  assign far_ext  = {1'b0, far_i};

  always_comb begin
    tag_c_d = tag_i;
    num_c_d = DW'(far_ext - root_i);
    den_c_d = far_i - near_i;
    if (tag_i.mode == dga_pkg::MODE_CALC) begin
      if (root_i <= near_ext) begin
        tag_c_d.mode = dga_pkg::MODE_FULL;
      end else if (far_ext <= root_i) begin
        // also covers far not above near
        tag_c_d.mode = dga_pkg::MODE_ZERO;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_c_q <= 1'b0;
    end else if (en_i) begin
      v_c_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_c_q <= tag_c_d;
      num_c_q <= num_c_d;
      den_c_q <= den_c_d;
    end
  end

  // divide stages; in calc mode the remainder stays below the divisor
  logic [DW-1:0]     rem_in [Steps];
  logic [DW-1:0]     den_in [Steps];
  logic [Steps-1:0]  q_in   [Steps];
  dga_pkg::tag_t     t_in   [Steps];
  logic              v_in   [Steps];

  logic [DW-1:0]     rem_q  [Steps];
  logic [DW-1:0]     den_q  [Steps];
  logic [Steps-1:0]  q_q    [Steps];
  dga_pkg::tag_t     t_q    [Steps];
  logic              v_q    [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [DW:0] twice;
    logic        take;

    if (s == 0) begin : g_first
      assign rem_in[s] = num_c_q;
      assign den_in[s] = den_c_q;
      assign q_in[s]   = '0;
      assign t_in[s]   = tag_c_q;
      assign v_in[s]   = v_c_q;
    end else begin : g_next
      assign rem_in[s] = rem_q[s-1];
      assign den_in[s] = den_q[s-1];
      assign q_in[s]   = q_q[s-1];
      assign t_in[s]   = t_q[s-1];
      assign v_in[s]   = v_q[s-1];
    end

    assign twice = {rem_in[s], 1'b0};
    assign take  = twice >= {1'b0, den_in[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_in[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= take ? DW'(twice - {1'b0, den_in[s]}) : DW'(twice);
        den_q[s] <= den_in[s];
        q_q[s]   <= {q_in[s][Steps-2:0], take};
        t_q[s]   <= t_in[s];
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign quot_o  = q_q[Steps-1];
  assign tag_o   = t_q[Steps-1];

endmodule

`default_nettype wire
